FILE: rtl/core/pvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_pkg - shared types and constants of the PCM voice mixer
// Request and response payloads, operation codes, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pvm_pkg;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_MIX   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // result kinds
    localparam logic KIND_HANDLE = 1'b0;
    localparam logic KIND_FRAME  = 1'b1;

    // handle counter restarts here after wrapping to zero
    localparam logic [15:0] HANDLE_FIRST = 16'd100;

    // scaling: gain*(b-128)*256/127, reciprocal of 127 scaled by 2^22 (floor)
    localparam int unsigned DIVISOR  = 127;
    localparam int unsigned RECIP    = 33026;
    localparam int unsigned RECIP_SH = 22;
    localparam logic signed [8:0] SAMPLE_BIAS = 9'sd128;
    localparam logic [8:0]  SEP_SPAN = 9'd257;

    // int16 saturation limits
    localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAT_MIN = -16'sh8000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] mem_address;
        logic [7:0]  mem_byte;
        logic [16:0] sound_length;
        logic [7:0]  sound_id;
        logic [6:0]  volume;
        logic [7:0]  separation;
        logic [17:0] step;
        logic        exclusive;
        logic [30:0] now_tick;
    } t_in_req;

    typedef struct packed {
        logic               result_kind;
        logic [15:0]        handle;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_out_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EXCL,
        ST_FREE,
        ST_GAIN1,
        ST_GAIN2,
        ST_WRITE,
        ST_MREAD,
        ST_MMUL,
        ST_MDIV,
        ST_MACC,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic mem_write;
        logic excl_step;
        logic free_step;
        logic gain1;
        logic gain2;
        logic voice_write;
        logic mix_read;
        logic mix_mul;
        logic mix_div;
        logic mix_acc;
        logic out_load;
        logic last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic excl_hit;
        logic free_hit;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/core/pvm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_req_if / pvm_rsp_if - valid/ready channels of the PCM voice mixer
// One request channel into the block and one response channel out of it.
// ----------------------------------------------------------------------------
interface pvm_req_if;
    logic             valid;
    logic             ready;
    pvm_pkg::t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pvm_rsp_if;
    logic              valid;
    logic              ready;
    pvm_pkg::t_out_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pvm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_ctrl - sequencer of the PCM voice mixer
// Walks the voices one per step for the exclusive stop, the slot search and
// the frame mix, and orders the gain and result steps.
// ----------------------------------------------------------------------------
module pvm_ctrl #(
    parameter int VOICES = 8,
    parameter int IW     = 3
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire  [1:0]       i_in_op,
    output logic             o_in_ready,
    input  pvm_pkg::t_sts    i_sts,
    output pvm_pkg::t_cmd    o_cmd,
    output logic [IW-1:0]    o_idx
);

    pvm_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic            w_last;
    logic            w_accept;

    assign w_last   = (r_idx == IW'(VOICES - 1));
    assign w_accept = i_in_valid && (r_state == pvm_pkg::ST_IDLE);
    assign o_idx    = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pvm_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state and voice index
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            pvm_pkg::ST_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    case (i_in_op)
                        pvm_pkg::OP_LOAD:  n_state = pvm_pkg::ST_LOAD;
                        pvm_pkg::OP_START: n_state = pvm_pkg::ST_EXCL;
                        pvm_pkg::OP_MIX:   n_state = pvm_pkg::ST_MREAD;
                        default:           n_state = pvm_pkg::ST_IDLE;
                    endcase
                end
            end
            pvm_pkg::ST_LOAD: n_state = pvm_pkg::ST_IDLE;
            pvm_pkg::ST_EXCL: begin
                if (i_sts.excl_hit || w_last) begin
                    n_state = pvm_pkg::ST_FREE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            pvm_pkg::ST_FREE: begin
                if (i_sts.free_hit || w_last) begin
                    n_state = pvm_pkg::ST_GAIN1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            pvm_pkg::ST_GAIN1: n_state = pvm_pkg::ST_GAIN2;
            pvm_pkg::ST_GAIN2: n_state = pvm_pkg::ST_WRITE;
            pvm_pkg::ST_WRITE: n_state = pvm_pkg::ST_DONE;
            pvm_pkg::ST_MREAD: n_state = pvm_pkg::ST_MMUL;
            pvm_pkg::ST_MMUL:  n_state = pvm_pkg::ST_MDIV;
            pvm_pkg::ST_MDIV:  n_state = pvm_pkg::ST_MACC;
            pvm_pkg::ST_MACC: begin
                if (w_last) begin
                    n_state = pvm_pkg::ST_DONE;
                end else begin
                    n_state = pvm_pkg::ST_MREAD;
                    n_idx   = r_idx + 1'b1;
                end
            end
            pvm_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = pvm_pkg::ST_IDLE;
                end
            end
            default: n_state = pvm_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.last  = w_last;
        o_in_ready  = (r_state == pvm_pkg::ST_IDLE);
        case (r_state)
            pvm_pkg::ST_IDLE:  o_cmd.capture     = w_accept;
            pvm_pkg::ST_LOAD:  o_cmd.mem_write   = 1'b1;
            pvm_pkg::ST_EXCL:  o_cmd.excl_step   = 1'b1;
            pvm_pkg::ST_FREE:  o_cmd.free_step   = 1'b1;
            pvm_pkg::ST_GAIN1: o_cmd.gain1       = 1'b1;
            pvm_pkg::ST_GAIN2: o_cmd.gain2       = 1'b1;
            pvm_pkg::ST_WRITE: o_cmd.voice_write = 1'b1;
            pvm_pkg::ST_MREAD: o_cmd.mix_read    = 1'b1;
            pvm_pkg::ST_MMUL:  o_cmd.mix_mul     = 1'b1;
            pvm_pkg::ST_MDIV:  o_cmd.mix_div     = 1'b1;
            pvm_pkg::ST_MACC:  o_cmd.mix_acc     = 1'b1;
            pvm_pkg::ST_DONE:  o_cmd.out_load    = i_sts.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/pvm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_datapath - voice state, sample memory and arithmetic of the mixer
// Holds the voice registers and sample RAM, computes gains and scaled
// samples, accumulates a frame and keeps the output register.
// ----------------------------------------------------------------------------
module pvm_datapath #(
    parameter int VOICES    = 8,
    parameter int ADDR_BITS = 16,
    parameter int IW        = 3
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pvm_pkg::t_in_req    i_req,
    input  pvm_pkg::t_cmd       i_cmd,
    input  wire  [IW-1:0]       i_idx,
    output pvm_pkg::t_sts       o_sts,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output pvm_pkg::t_out_rsp   o_out_data
);

    localparam int PW    = ADDR_BITS + 1;
    localparam int EW    = ((ADDR_BITS > 17) ? ADDR_BITS : 17) + 1;
    localparam int ACC_W = 18 + $clog2(VOICES);
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    // latched request
    pvm_pkg::t_in_req r_req;

    // voice state
    logic [VOICES-1:0] r_active;
    logic [PW-1:0]     r_pos   [VOICES];
    logic [PW-1:0]     r_end   [VOICES];
    logic [15:0]       r_frac  [VOICES];
    logic [17:0]       r_step  [VOICES];
    logic [6:0]        r_gl    [VOICES];
    logic [6:0]        r_gr    [VOICES];
    logic [30:0]       r_tick  [VOICES];
    logic [7:0]        r_sound [VOICES];
    logic [15:0]       r_handle_cnt;

    // sample memory
    logic [7:0] r_mem [2**ADDR_BITS];
    logic [7:0] r_rd_byte;

    // start working registers
    logic [IW-1:0]  r_slot, r_old_idx;
    logic [30:0]    r_oldest;
    logic [16:0]    r_sq_l, r_sq_r;
    logic [6:0]     r_new_gl, r_new_gr;
    logic [15:0]    r_handle;

    // mix working registers
    logic [14:0]    r_tl, r_tr;
    logic           r_neg_l, r_neg_r;
    logic [8:0]     r_q0l, r_q0r;
    logic signed [ACC_W-1:0] r_acc_l, r_acc_r;

    // output register
    logic              r_out_valid;
    pvm_pkg::t_out_rsp r_out;

    // status
    assign o_sts.excl_hit = r_req.exclusive && r_active[i_idx]
                            && (r_sound[i_idx] == r_req.sound_id);
    assign o_sts.free_hit = !r_active[i_idx];
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            r_mem[ADDR_BITS'(r_req.mem_address)] <= r_req.mem_byte;
        end
        if (i_cmd.mix_read) begin
            r_rd_byte <= r_mem[r_pos[i_idx][ADDR_BITS-1:0]];
        end
    end

    // gain products
    logic [8:0]  w_sep1, w_inv;
    logic [23:0] w_pl, w_pr;
    assign w_sep1 = {1'b0, r_req.separation} + 9'd1;
    assign w_inv  = pvm_pkg::SEP_SPAN - w_sep1;
    assign w_pl   = r_req.volume * r_sq_l;
    assign w_pr   = r_req.volume * r_sq_r;

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain1) begin
            r_sq_l <= 17'(w_sep1 * w_sep1);
            r_sq_r <= 17'(w_inv * w_inv);
        end
        if (i_cmd.gain2) begin
            r_new_gl <= r_req.volume - w_pl[22:16];
            r_new_gr <= r_req.volume - w_pr[22:16];
        end
    end

    // slot search over the voices
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_oldest  <= i_req.now_tick;
            r_old_idx <= '0;
        end
        if (i_cmd.free_step) begin
            if (!r_active[i_idx]) begin
                r_slot <= i_idx;
            end else if (r_tick[i_idx] < r_oldest) begin
                r_oldest  <= r_tick[i_idx];
                r_old_idx <= i_idx;
                r_slot    <= i_idx;
            end else begin
                r_slot <= r_old_idx;
            end
        end
    end

    // end address with saturation
    logic [EW-1:0] w_end_sum;
    logic [PW-1:0] w_end;
    assign w_end_sum = EW'(ADDR_BITS'(r_req.mem_address)) + EW'(r_req.sound_length);
    assign w_end     = (w_end_sum > EW'(POS_MAX)) ? POS_MAX : w_end_sum[PW-1:0];

    // scaled sample: |gain*(b-128)|*2 = t, result t + floor(t/127)
    logic signed [8:0]  w_d;
    logic signed [16:0] w_xl, w_xr;
    logic [15:0]        w_axl, w_axr;
    assign w_d   = $signed({1'b0, r_rd_byte}) - pvm_pkg::SAMPLE_BIAS;
    assign w_xl  = $signed({1'b0, r_gl[i_idx]}) * w_d;
    assign w_xr  = $signed({1'b0, r_gr[i_idx]}) * w_d;
    assign w_axl = w_xl[16] ? 16'(-w_xl) : w_xl[15:0];
    assign w_axr = w_xr[16] ? 16'(-w_xr) : w_xr[15:0];

    logic [30:0] w_pql, w_pqr;
    assign w_pql = 31'(r_tl) * 31'(pvm_pkg::RECIP);
    assign w_pqr = 31'(r_tr) * 31'(pvm_pkg::RECIP);

    function automatic logic [15:0] fin_mag(input logic [14:0] t, input logic [8:0] q0);
        logic [15:0] rem;
        logic [8:0]  q;
        rem = 16'(t) - 16'(q0) * 16'(pvm_pkg::DIVISOR);
        q   = (rem >= 16'(pvm_pkg::DIVISOR)) ? q0 + 9'd1 : q0;
        return 16'(t) + 16'(q);
    endfunction

    logic [15:0]             w_ml, w_mr;
    logic signed [ACC_W-1:0] w_term_l, w_term_r;
    assign w_ml     = fin_mag(r_tl, r_q0l);
    assign w_mr     = fin_mag(r_tr, r_q0r);
    assign w_term_l = r_neg_l ? -$signed(ACC_W'(w_ml)) : $signed(ACC_W'(w_ml));
    assign w_term_r = r_neg_r ? -$signed(ACC_W'(w_mr)) : $signed(ACC_W'(w_mr));

    // position advance
    logic [18:0]   w_frac_sum;
    logic [PW:0]   w_np;
    assign w_frac_sum = 19'(r_frac[i_idx]) + 19'(r_step[i_idx]);
    assign w_np       = (PW + 1)'(r_pos[i_idx]) + (PW + 1)'(w_frac_sum[18:16]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end
        if (i_cmd.mix_mul) begin
            r_tl    <= {w_axl[13:0], 1'b0};
            r_tr    <= {w_axr[13:0], 1'b0};
            r_neg_l <= w_xl[16];
            r_neg_r <= w_xr[16];
        end
        if (i_cmd.mix_div) begin
            r_q0l <= w_pql[pvm_pkg::RECIP_SH +: 9];
            r_q0r <= w_pqr[pvm_pkg::RECIP_SH +: 9];
        end
        if (i_cmd.mix_acc && r_active[i_idx]) begin
            r_acc_l <= r_acc_l + w_term_l;
            r_acc_r <= r_acc_r + w_term_r;
        end
    end

    // voice registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.voice_write) begin
            r_pos[r_slot]   <= PW'(ADDR_BITS'(r_req.mem_address));
            r_end[r_slot]   <= w_end;
            r_frac[r_slot]  <= '0;
            r_step[r_slot]  <= r_req.step;
            r_gl[r_slot]    <= r_new_gl;
            r_gr[r_slot]    <= r_new_gr;
            r_tick[r_slot]  <= r_req.now_tick;
            r_sound[r_slot] <= r_req.sound_id;
        end
        if (i_cmd.mix_acc && r_active[i_idx]) begin
            r_frac[i_idx] <= w_frac_sum[15:0];
            r_pos[i_idx]  <= w_np[PW-1:0];
        end
    end

    // active flags and handle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_handle_cnt <= '0;
        end else begin
            if (i_cmd.excl_step && o_sts.excl_hit) begin
                r_active[i_idx] <= 1'b0;
            end
            if (i_cmd.voice_write) begin
                r_active[r_slot] <= 1'b1;
                r_handle_cnt     <= ((r_handle_cnt == '0) ? pvm_pkg::HANDLE_FIRST
                                                          : r_handle_cnt) + 16'd1;
            end
            if (i_cmd.mix_acc && r_active[i_idx]
                && (w_np >= (PW + 1)'(r_end[i_idx]))) begin
                r_active[i_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.voice_write) begin
            r_handle <= (r_handle_cnt == '0) ? pvm_pkg::HANDLE_FIRST : r_handle_cnt;
        end
    end

    // saturate to int16
    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(pvm_pkg::SAT_MAX)) begin
            return pvm_pkg::SAT_MAX;
        end else if (v < ACC_W'(pvm_pkg::SAT_MIN)) begin
            return pvm_pkg::SAT_MIN;
        end
        return v[15:0];
    endfunction

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_req.op == pvm_pkg::OP_START) begin
                r_out.result_kind  <= pvm_pkg::KIND_HANDLE;
                r_out.handle       <= r_handle;
                r_out.left_sample  <= '0;
                r_out.right_sample <= '0;
            end else begin
                r_out.result_kind  <= pvm_pkg::KIND_FRAME;
                r_out.handle       <= '0;
                r_out.left_sample  <= sat16(r_acc_l);
                r_out.right_sample <= sat16(r_acc_r);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/pcm_voice_mixer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: load writes one sample byte; start runs the exclusive scan,
//   slot scan, two gain multiply steps and write; mix visits every voice.
// Requests: one request at a time; the voice loop takes each voice through
//   read, multiply, divide and accumulate via the shared multiply/reciprocal unit and sample RAM port.
// Reset: synchronous active low; clears active flags, handle counter, state.
//   Sample memory is not cleared.
// ----------------------------------------------------------------------------
// pcm_voice_mixer_unit - stereo PCM mixer of VOICES voices (eight by default), top level
// Joins the sequencer and the datapath to the request and response channels.
// ----------------------------------------------------------------------------
module pcm_voice_mixer_unit #(
    parameter int VOICES    = 8,
    parameter int ADDR_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pvm_req_if.sink    i_req,
    pvm_rsp_if.source  o_rsp
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

    pvm_pkg::t_cmd w_cmd;
    pvm_pkg::t_sts w_sts;
    logic [IW-1:0] w_idx;

    pvm_ctrl #(
        .VOICES (VOICES),
        .IW     (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_op    (i_req.data.op),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    pvm_datapath #(
        .VOICES    (VOICES),
        .ADDR_BITS (ADDR_BITS),
        .IW        (IW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req.data),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .o_sts       (w_sts),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_out_data  (o_rsp.data)
    );

`ifndef SYNTH
    // no request is taken while a result is being loaded
    a_no_accept_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.valid && i_req.ready && w_cmd.out_load))
        else $error("request accepted during result load");

    // a fresh result follows a load command
    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_cmd.out_load))
        else $error("result valid without load");

    // handle results carry silent samples
    a_handle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.data.result_kind == pvm_pkg::KIND_HANDLE))
        |-> (o_rsp.data.left_sample == '0) && (o_rsp.data.right_sample == '0))
        else $error("handle result with nonzero samples");
`endif

endmodule
`default_nettype wire
